### hw/rtl/vtdfa_pkg.sv
// Shared types and codes for the vertex tuple dedup fan assembler.
package vtdfa_pkg;

    localparam logic [1:0] CMD_CORNER = 2'd0;
    localparam logic [1:0] CMD_END_FACE = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] KIND_VERTEX = 2'd0;
    localparam logic [1:0] KIND_TRIANGLE = 2'd1;
    localparam logic [1:0] KIND_OVERFLOW = 2'd2;

    localparam logic [1:0] CFG_USE_TEXTURE = 2'd0;
    localparam logic [1:0] CFG_USE_COLOR = 2'd1;
    localparam logic [1:0] CFG_USE_NORMAL = 2'd2;

    localparam int FIELD_W = 20;
    localparam int NUM_W = 12;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_HASH,
        ST_READ,
        ST_CHECK,
        ST_EMIT_VERTEX,
        ST_EMIT_TRI
    } state_t;

endpackage

### hw/rtl/vtdfa_slot_mem.sv
// Hash slot memory: key, valid and vertex number per slot, registered read.
module vtdfa_slot_mem #(
    parameter int SLOT_BITS = 13,
    parameter int KEY_W = 80,
    parameter int NUM_BITS = 12
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [SLOT_BITS-1:0] wr_addr,
    input  logic                 wr_valid,
    input  logic [KEY_W-1:0]     wr_key,
    input  logic [NUM_BITS-1:0]  wr_num,
    input  logic [SLOT_BITS-1:0] rd_addr,
    output logic                 rd_valid,
    output logic [KEY_W-1:0]     rd_key,
    output logic [NUM_BITS-1:0]  rd_num
);

    localparam int DEPTH = 1 << SLOT_BITS;
    localparam int ENTRY_W = 1 + KEY_W + NUM_BITS;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_valid, wr_key, wr_num};
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_valid = rd_data_reg[ENTRY_W-1];
    assign rd_key = rd_data_reg[ENTRY_W-2:NUM_BITS];
    assign rd_num = rd_data_reg[NUM_BITS-1:0];

endmodule

### hw/rtl/vertex_tuple_dedup_fan_assembler_core.sv
// Top level of the vertex tuple dedup fan assembler.
// Input beats on s_* carry a command and a corner tuple; result beats on m_*
// carry vertex records, fan triangles or an overflow flag, with m_last on
// the final result of each input beat.
// Configuration writes on cfg_* set which tuple components are kept.
// One input beat is handled at a time. A corner passes through a hash
// state, then a read and a compare state for each probe of the slot memory,
// plus a triangle state when a triangle is due; a vertex or overflow beat
// is loaded in the compare state. The probe loop runs on the single read
// port of the slot memory. End of face is handled in the idle state.
// After reset, and after each clear command, a clearing pass writes every
// slot invalid, one slot per cycle, during which no input beat is accepted;
// configuration writes are taken throughout.
// A result beat is held in the output register until m_ready is high;
// the block waits for it only before loading the next result beat.
module vertex_tuple_dedup_fan_assembler_core #(
    parameter int MAX_VERTICES = 4096,
    parameter int HASH_SLOTS = 8192,
    parameter int INDEX_BITS = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [19:0] s_texture_index,
    input  logic [19:0] s_color_index,
    input  logic [19:0] s_normal_index,
    input  logic [19:0] s_position_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [11:0] m_vertex_number,
    output logic [19:0] m_out_texture_index,
    output logic [19:0] m_out_color_index,
    output logic [19:0] m_out_normal_index,
    output logic [19:0] m_out_position_index,
    output logic [11:0] m_corner_a,
    output logic [11:0] m_corner_b,
    output logic [11:0] m_corner_c,
    output logic        m_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [0:0]  cfg_data
);

    localparam int SLOT_BITS = $clog2(HASH_SLOTS);
    localparam int CNT_BITS = $clog2(MAX_VERTICES + 1);
    localparam int KEY_W = 4 * INDEX_BITS;
    localparam int HASH_W = INDEX_BITS + 7;
    localparam int NW = vtdfa_pkg::NUM_W;
    localparam int FW = vtdfa_pkg::FIELD_W;

    vtdfa_pkg::state_t state_reg, state_next;

    logic use_t_reg, use_c_reg, use_n_reg;
    logic [INDEX_BITS-1:0] t_reg, c_reg, n_reg, p_reg;
    logic [SLOT_BITS-1:0] slot_reg, slot_next;
    logic [SLOT_BITS:0] probes_reg, probes_next;
    logic [CNT_BITS-1:0] nvn_reg, nvn_next;
    logic [NW-1:0] fan_first_reg, fan_first_next;
    logic [NW-1:0] fan_prev_reg, fan_prev_next;
    logic [1:0] cif_reg, cif_next;
    logic [NW-1:0] vnum_reg, vnum_next;
    logic [HASH_W-1:0] hash_sum;
    logic [KEY_W-1:0] key;

    logic mem_we, mem_wvalid, rd_valid;
    logic [KEY_W-1:0] rd_key;
    logic [NW-1:0] rd_num;
    logic [SLOT_BITS-1:0] mem_waddr;

    logic out_valid_reg, out_valid_next;
    logic [1:0] out_kind_reg, out_kind_next;
    logic out_last_reg, out_last_next;
    logic [NW-1:0] out_vn_reg, out_vn_next;
    logic [NW-1:0] out_a_reg, out_a_next, out_b_reg, out_b_next, out_c_reg, out_c_next;
    logic [FW-1:0] out_t_reg, out_t_next, out_cl_reg, out_cl_next;
    logic [FW-1:0] out_n_reg, out_n_next, out_p_reg, out_p_next;

    logic tri_pending;
    logic out_free;

    assign key = {p_reg, t_reg, c_reg, n_reg};
    assign hash_sum = ((HASH_W'(t_reg) * HASH_W'(7) + HASH_W'(c_reg)) * HASH_W'(5))
                      + HASH_W'(n_reg) * HASH_W'(3) + HASH_W'(p_reg);
    assign tri_pending = (cif_reg == 2'd2);
    assign out_free = !out_valid_reg || m_ready;

    vtdfa_slot_mem #(
        .SLOT_BITS(SLOT_BITS),
        .KEY_W(KEY_W),
        .NUM_BITS(NW)
    ) u_slot_mem (
        .aclk(aclk),
        .wr_en(mem_we),
        .wr_addr(mem_waddr),
        .wr_valid(mem_wvalid),
        .wr_key(key),
        .wr_num(NW'(nvn_reg)),
        .rd_addr(slot_reg),
        .rd_valid(rd_valid),
        .rd_key(rd_key),
        .rd_num(rd_num)
    );

    assign cfg_ready = 1'b1;
    assign s_ready = (state_reg == vtdfa_pkg::ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_t_reg <= 1'b0;
            use_c_reg <= 1'b0;
            use_n_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                vtdfa_pkg::CFG_USE_TEXTURE: use_t_reg <= cfg_data[0];
                vtdfa_pkg::CFG_USE_COLOR: use_c_reg <= cfg_data[0];
                vtdfa_pkg::CFG_USE_NORMAL: use_n_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            t_reg <= use_t_reg ? s_texture_index[INDEX_BITS-1:0] : '0;
            c_reg <= use_c_reg ? s_color_index[INDEX_BITS-1:0] : '0;
            n_reg <= use_n_reg ? s_normal_index[INDEX_BITS-1:0] : '0;
            p_reg <= s_position_index[INDEX_BITS-1:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            vtdfa_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_command == vtdfa_pkg::CMD_CORNER) begin
                        state_next = vtdfa_pkg::ST_HASH;
                    end else if (s_command == vtdfa_pkg::CMD_CLEAR) begin
                        state_next = vtdfa_pkg::ST_CLEAR;
                    end
                end
            end
            vtdfa_pkg::ST_CLEAR: begin
                if (slot_reg == SLOT_BITS'(HASH_SLOTS - 1)) begin
                    state_next = vtdfa_pkg::ST_IDLE;
                end
            end
            vtdfa_pkg::ST_HASH: state_next = vtdfa_pkg::ST_READ;
            vtdfa_pkg::ST_READ: state_next = vtdfa_pkg::ST_CHECK;
            vtdfa_pkg::ST_CHECK: begin
                if (rd_valid && rd_key == key) begin
                    if (!tri_pending) begin
                        state_next = vtdfa_pkg::ST_IDLE;
                    end else begin
                        state_next = vtdfa_pkg::ST_EMIT_TRI;
                    end
                end else if (!rd_valid || probes_reg == (SLOT_BITS + 1)'(HASH_SLOTS)) begin
                    if (out_free) begin
                        if (nvn_reg >= CNT_BITS'(MAX_VERTICES) || rd_valid) begin
                            state_next = vtdfa_pkg::ST_IDLE;
                        end else begin
                            state_next = tri_pending ? vtdfa_pkg::ST_EMIT_TRI
                                                     : vtdfa_pkg::ST_IDLE;
                        end
                    end
                end else begin
                    state_next = vtdfa_pkg::ST_READ;
                end
            end
            vtdfa_pkg::ST_EMIT_TRI: begin
                if (out_free) begin
                    state_next = vtdfa_pkg::ST_IDLE;
                end
            end
            default: state_next = vtdfa_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        slot_next = slot_reg;
        probes_next = probes_reg;
        nvn_next = nvn_reg;
        fan_first_next = fan_first_reg;
        fan_prev_next = fan_prev_reg;
        cif_next = cif_reg;
        vnum_next = vnum_reg;
        mem_we = 1'b0;
        mem_wvalid = 1'b0;
        mem_waddr = slot_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_kind_next = out_kind_reg;
        out_last_next = out_last_reg;
        out_vn_next = out_vn_reg;
        out_a_next = out_a_reg;
        out_b_next = out_b_reg;
        out_c_next = out_c_reg;
        out_t_next = out_t_reg;
        out_cl_next = out_cl_reg;
        out_n_next = out_n_reg;
        out_p_next = out_p_reg;
        case (state_reg)
            vtdfa_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_command == vtdfa_pkg::CMD_END_FACE) begin
                        cif_next = 2'd0;
                    end else if (s_command == vtdfa_pkg::CMD_CLEAR) begin
                        slot_next = '0;
                        nvn_next = '0;
                        fan_first_next = '0;
                        fan_prev_next = '0;
                        cif_next = 2'd0;
                    end
                end
            end
            vtdfa_pkg::ST_CLEAR: begin
                mem_we = 1'b1;
                slot_next = slot_reg + SLOT_BITS'(1);
            end
            vtdfa_pkg::ST_HASH: begin
                slot_next = hash_sum[SLOT_BITS-1:0];
                probes_next = '0;
            end
            vtdfa_pkg::ST_READ: begin
                probes_next = probes_reg + (SLOT_BITS + 1)'(1);
            end
            vtdfa_pkg::ST_CHECK: begin
                if (rd_valid && rd_key == key) begin
                    vnum_next = rd_num;
                    if (cif_reg == 2'd0) begin
                        fan_first_next = rd_num;
                        cif_next = 2'd1;
                    end else if (cif_reg == 2'd1) begin
                        fan_prev_next = rd_num;
                        cif_next = 2'd2;
                    end
                end else if (!rd_valid || probes_reg == (SLOT_BITS + 1)'(HASH_SLOTS)) begin
                    if (out_free) begin
                        out_valid_next = 1'b1;
                        out_vn_next = '0;
                        out_a_next = '0;
                        out_b_next = '0;
                        out_c_next = '0;
                        out_t_next = '0;
                        out_cl_next = '0;
                        out_n_next = '0;
                        out_p_next = '0;
                        if (nvn_reg >= CNT_BITS'(MAX_VERTICES) || rd_valid) begin
                            out_kind_next = vtdfa_pkg::KIND_OVERFLOW;
                            out_last_next = 1'b1;
                        end else begin
                            mem_we = 1'b1;
                            mem_wvalid = 1'b1;
                            nvn_next = nvn_reg + CNT_BITS'(1);
                            vnum_next = NW'(nvn_reg);
                            out_kind_next = vtdfa_pkg::KIND_VERTEX;
                            out_last_next = !tri_pending;
                            out_vn_next = NW'(nvn_reg);
                            out_t_next = FW'(t_reg);
                            out_cl_next = FW'(c_reg);
                            out_n_next = FW'(n_reg);
                            out_p_next = FW'(p_reg);
                            if (cif_reg == 2'd0) begin
                                fan_first_next = NW'(nvn_reg);
                                cif_next = 2'd1;
                            end else if (cif_reg == 2'd1) begin
                                fan_prev_next = NW'(nvn_reg);
                                cif_next = 2'd2;
                            end
                        end
                    end
                end else begin
                    slot_next = slot_reg + SLOT_BITS'(1);
                end
            end
            vtdfa_pkg::ST_EMIT_TRI: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next = vtdfa_pkg::KIND_TRIANGLE;
                    out_last_next = 1'b1;
                    out_vn_next = '0;
                    out_t_next = '0;
                    out_cl_next = '0;
                    out_n_next = '0;
                    out_p_next = '0;
                    out_a_next = fan_first_reg;
                    out_b_next = fan_prev_reg;
                    out_c_next = vnum_reg;
                    fan_prev_next = vnum_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vtdfa_pkg::ST_CLEAR;
            slot_reg <= '0;
            probes_reg <= '0;
            nvn_reg <= '0;
            fan_first_reg <= '0;
            fan_prev_reg <= '0;
            cif_reg <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            slot_reg <= slot_next;
            probes_reg <= probes_next;
            nvn_reg <= nvn_next;
            fan_first_reg <= fan_first_next;
            fan_prev_reg <= fan_prev_next;
            cif_reg <= cif_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        vnum_reg <= vnum_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
        out_vn_reg <= out_vn_next;
        out_a_reg <= out_a_next;
        out_b_reg <= out_b_next;
        out_c_reg <= out_c_next;
        out_t_reg <= out_t_next;
        out_cl_reg <= out_cl_next;
        out_n_reg <= out_n_next;
        out_p_reg <= out_p_next;
    end

    assign m_valid = out_valid_reg;
    assign m_kind = out_kind_reg;
    assign m_last = out_last_reg;
    assign m_vertex_number = out_vn_reg;
    assign m_out_texture_index = out_t_reg;
    assign m_out_color_index = out_cl_reg;
    assign m_out_normal_index = out_n_reg;
    assign m_out_position_index = out_p_reg;
    assign m_corner_a = out_a_reg;
    assign m_corner_b = out_b_reg;
    assign m_corner_c = out_c_reg;

endmodule

### tb/vtdfa_checker.sv
// Checker for the vertex tuple dedup fan assembler: predicts and compares result beats.
module vtdfa_checker #(
    parameter int MAX_VERTICES = 4096,
    parameter int HASH_SLOTS = 8192
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [19:0] s_texture_index,
    input  logic [19:0] s_color_index,
    input  logic [19:0] s_normal_index,
    input  logic [19:0] s_position_index,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_kind,
    input  logic [11:0] m_vertex_number,
    input  logic [19:0] m_out_texture_index,
    input  logic [19:0] m_out_color_index,
    input  logic [19:0] m_out_normal_index,
    input  logic [19:0] m_out_position_index,
    input  logic [11:0] m_corner_a,
    input  logic [11:0] m_corner_b,
    input  logic [11:0] m_corner_c,
    input  logic        m_last,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [0:0]  cfg_data,
    output int          fail_count,
    output int          pending,
    output int          beats_checked
);

    typedef struct {
        logic [1:0]  kind;
        logic [11:0] vnum;
        logic [19:0] tex;
        logic [19:0] col;
        logic [19:0] nrm;
        logic [19:0] pos;
        logic [11:0] ca;
        logic [11:0] cb;
        logic [11:0] cc;
        logic        last;
    } fan_result_t;

    fan_result_t expected_beats[$];

    logic        keep_tex, keep_col, keep_nrm;
    logic        slot_used [HASH_SLOTS];
    logic [19:0] slot_tex [HASH_SLOTS];
    logic [19:0] slot_col [HASH_SLOTS];
    logic [19:0] slot_nrm [HASH_SLOTS];
    logic [19:0] slot_pos [HASH_SLOTS];
    logic [11:0] slot_num [HASH_SLOTS];
    logic [12:0] next_num;
    logic [11:0] fan_center, fan_prev;
    int          face_corners;

    assign pending = expected_beats.size();

    task automatic queue_beat(input fan_result_t r);
        expected_beats.insert(expected_beats.size(), r);
    endtask

    task automatic clear_mesh();
        for (int i = 0; i < HASH_SLOTS; i++) slot_used[i] = 1'b0;
        next_num = '0;
        fan_center = '0;
        fan_prev = '0;
        face_corners = 0;
    endtask

    task automatic predict_corner(input logic [19:0] t_in, input logic [19:0] c_in,
                                  input logic [19:0] n_in, input logic [19:0] p_in);
        fan_result_t r;
        logic [19:0] t, c, n;
        longint      home;
        int          slot;
        bit          found, has_free;
        logic [11:0] num;
        t = keep_tex ? t_in : '0;
        c = keep_col ? c_in : '0;
        n = keep_nrm ? n_in : '0;
        home = ((longint'(t) * 7 + c) * 5 + longint'(n) * 3 + p_in) % HASH_SLOTS;
        slot = int'(home);
        found = 0;
        has_free = 0;
        num = '0;
        for (int k = 0; k < HASH_SLOTS; k++) begin
            if (!slot_used[slot]) begin
                has_free = 1;
                break;
            end
            if (slot_tex[slot] == t && slot_col[slot] == c && slot_nrm[slot] == n &&
                slot_pos[slot] == p_in) begin
                found = 1;
                num = slot_num[slot];
                break;
            end
            slot = (slot + 1) % HASH_SLOTS;
        end
        r = '{default: '0};
        if (!found) begin
            if (!has_free || next_num >= MAX_VERTICES) begin
                r.kind = vtdfa_pkg::KIND_OVERFLOW;
                r.last = 1'b1;
                queue_beat(r);
                return;
            end
            num = next_num[11:0];
            slot_used[slot] = 1'b1;
            slot_tex[slot] = t;
            slot_col[slot] = c;
            slot_nrm[slot] = n;
            slot_pos[slot] = p_in;
            slot_num[slot] = num;
            next_num = next_num + 13'd1;
            r.kind = vtdfa_pkg::KIND_VERTEX;
            r.vnum = num;
            r.tex = t;
            r.col = c;
            r.nrm = n;
            r.pos = p_in;
            r.last = (face_corners < 2);
            queue_beat(r);
        end
        if (face_corners == 0) begin
            fan_center = num;
            face_corners = 1;
        end else if (face_corners == 1) begin
            fan_prev = num;
            face_corners = 2;
        end else begin
            r = '{default: '0};
            r.kind = vtdfa_pkg::KIND_TRIANGLE;
            r.ca = fan_center;
            r.cb = fan_prev;
            r.cc = num;
            r.last = 1'b1;
            queue_beat(r);
            fan_prev = num;
        end
    endtask

    task automatic check_field(input string name, input logic [19:0] exp_v,
                               input logic [19:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: mismatch on %s, expected %0h, actual %0h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        fan_result_t e;
        if (!aresetn) begin
            keep_tex = 1'b0;
            keep_col = 1'b0;
            keep_nrm = 1'b0;
            clear_mesh();
            expected_beats.delete();
            fail_count = 0;
            beats_checked <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    vtdfa_pkg::CFG_USE_TEXTURE: keep_tex = cfg_data[0];
                    vtdfa_pkg::CFG_USE_COLOR: keep_col = cfg_data[0];
                    vtdfa_pkg::CFG_USE_NORMAL: keep_nrm = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                case (s_command)
                    vtdfa_pkg::CMD_CORNER: predict_corner(s_texture_index, s_color_index,
                                                          s_normal_index, s_position_index);
                    vtdfa_pkg::CMD_END_FACE: face_corners = 0;
                    vtdfa_pkg::CMD_CLEAR: clear_mesh();
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                beats_checked <= beats_checked + 1;
                if (expected_beats.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual kind %0d",
                             $time, m_kind);
                    fail_count++;
                end else begin
                    e = expected_beats.pop_front();
                    check_field("kind", 20'(e.kind), 20'(m_kind));
                    check_field("vertex_number", 20'(e.vnum), 20'(m_vertex_number));
                    check_field("texture_index", e.tex, m_out_texture_index);
                    check_field("color_index", e.col, m_out_color_index);
                    check_field("normal_index", e.nrm, m_out_normal_index);
                    check_field("position_index", e.pos, m_out_position_index);
                    check_field("corner_a", 20'(e.ca), 20'(m_corner_a));
                    check_field("corner_b", 20'(e.cb), 20'(m_corner_b));
                    check_field("corner_c", 20'(e.cc), 20'(m_corner_c));
                    check_field("last", 20'(e.last), 20'(m_last));
                end
            end
        end
    end

endmodule

### tb/tb_top.sv
// Top of the testbench: clock, reset, stimulus and verdict for the fan assembler.
module tb_top;

    localparam int CYCLE_LIMIT = 3000000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] CFG_INDEX_UNUSED = 2'd3;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command = vtdfa_pkg::CMD_END_FACE;
    logic [19:0] s_texture_index = '0;
    logic [19:0] s_color_index = '0;
    logic [19:0] s_normal_index = '0;
    logic [19:0] s_position_index = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic [11:0] m_vertex_number;
    logic [19:0] m_out_texture_index;
    logic [19:0] m_out_color_index;
    logic [19:0] m_out_normal_index;
    logic [19:0] m_out_position_index;
    logic [11:0] m_corner_a;
    logic [11:0] m_corner_b;
    logic [11:0] m_corner_c;
    logic        m_last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [0:0]  cfg_data = '0;

    int fail_count;
    int pending;
    int beats_checked;
    int max_wait = 9;
    int stall_left = 0;
    int cycles = 0;
    int items_sent = 0;
    int meshes = 0;

    logic [19:0] pool [16][4];

    always #5 aclk = ~aclk;

    vertex_tuple_dedup_fan_assembler_core DUT (.*);

    vtdfa_checker u_checker (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    always @(posedge aclk) begin
        int n;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (m_ready && m_valid) begin
            n = $urandom_range(0, max_wait);
            m_ready <= (n == 0);
            stall_left <= (n > 0) ? n - 1 : 0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send(input logic [1:0] cmd, input logic [19:0] t, input logic [19:0] c,
                        input logic [19:0] n, input logic [19:0] p);
        int gap;
        gap = $urandom_range(0, max_wait);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_texture_index <= t;
        s_color_index <= c;
        s_normal_index <= n;
        s_position_index <= p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic corner(input logic [19:0] t, input logic [19:0] c, input logic [19:0] n,
                          input logic [19:0] p);
        send(vtdfa_pkg::CMD_CORNER, t, c, n, p);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle_and_configure(input logic [2:0] keep);
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);
        write_reg(vtdfa_pkg::CFG_USE_TEXTURE, keep[0]);
        write_reg(vtdfa_pkg::CFG_USE_COLOR, keep[1]);
        write_reg(vtdfa_pkg::CFG_USE_NORMAL, keep[2]);
    endtask

    function automatic logic [19:0] draw_index();
        case ($urandom_range(0, 3))
            0: return 20'($urandom_range(0, 15));
            1: return $urandom_range(0, 1) ? 20'hFFFFF : 20'h0;
            default: return 20'($urandom_range(0, 20'hFFFFF));
        endcase
    endfunction

    initial begin
        int corners;
        int pick;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: extremes, every command, short faces, repeats and noise.
        settle_and_configure(3'b111);
        write_reg(CFG_INDEX_UNUSED, 1'b1);
        corner(20'h0, 20'h0, 20'h0, 20'h0);
        corner(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
        corner(20'h0, 20'h0, 20'h0, 20'h0);
        corner(20'h12345, 20'hABCDE, 20'h5A5A5, 20'hA5A5A);
        send(vtdfa_pkg::CMD_END_FACE, 20'h0, 20'h0, 20'h0, 20'h0);
        corner(20'h1, 20'h2, 20'h3, 20'h4);
        corner(20'h7, 20'h0, 20'h0, 20'h0);
        send(vtdfa_pkg::CMD_END_FACE, 20'h0, 20'h0, 20'h0, 20'h0);
        send(CMD_UNUSED, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
        corner(20'h0, 20'h0, 20'h5, 20'h0);
        corner(20'h0, 20'h0, 20'h0, 20'h23);
        corner(20'h1, 20'h2, 20'h3, 20'h4);
        send(vtdfa_pkg::CMD_END_FACE, 20'h0, 20'h0, 20'h0, 20'h0);
        send(vtdfa_pkg::CMD_CLEAR, 20'h0, 20'h0, 20'h0, 20'h0);
        corner(20'h1, 20'h2, 20'h3, 20'h4);
        corner(20'hFFFFF, 20'h0, 20'hFFFFF, 20'h0);
        corner(20'h1, 20'h2, 20'h3, 20'h4);
        settle_and_configure(3'b000);
        corner(20'h1, 20'h2, 20'h3, 20'h4);
        corner(20'h9, 20'h8, 20'h7, 20'h4);
        corner(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'h4);

        // Random meshes of faces drawn mostly from a small tuple pool, with some fresh tuples.
        for (int ph = 0; ph < 8; ph++) begin
            max_wait = (ph % 3 == 2) ? 0 : 9;
            settle_and_configure(ph == 7 ? 3'b111 : 3'($urandom_range(0, 7)));
            for (int m = 0; m < 3; m++) begin
                send(vtdfa_pkg::CMD_CLEAR, draw_index(), draw_index(), draw_index(),
                     draw_index());
                meshes++;
                for (int i = 0; i < 16; i++)
                    for (int j = 0; j < 4; j++) pool[i][j] = draw_index();
                for (int f = 0; f < 14; f++) begin
                    corners = $urandom_range(1, 6);
                    for (int k = 0; k < corners; k++) begin
                        pick = $urandom_range(0, 15);
                        if ($urandom_range(0, 9) < 7)
                            corner(pool[pick][0], pool[pick][1], pool[pick][2], pool[pick][3]);
                        else
                            corner(draw_index(), draw_index(), draw_index(), draw_index());
                        if ($urandom_range(0, 39) == 0)
                            send(CMD_UNUSED, draw_index(), draw_index(), draw_index(),
                                 draw_index());
                    end
                    send(vtdfa_pkg::CMD_END_FACE, draw_index(), draw_index(), draw_index(),
                         draw_index());
                end
            end
        end

        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("Sent %0d input beats over %0d random meshes after a directed opening.",
                 items_sent, meshes);
        $display("Checked %0d result beats across several keep settings.", beats_checked);
        if (fail_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
